// ===== hw/rtl/tcs_pkg.sv =====
package tcs_pkg;

  // Item kinds as they arrive on the input stream.
  localparam logic [1:0] KIND_PUT   = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] COLOR_RESET  = 8'd245;

  // Operations after classification by the front end.
  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_WRITE,
    OP_READ,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] code;
    logic [7:0] color;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCROLL,
    ST_DRAIN,
    ST_CLEAR,
    ST_READ
  } state_t;

endpackage

// ===== hw/rtl/tcs_ram.sv =====
module tcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/tcs_front.sv =====
module tcs_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_kind,
  input  logic [7:0]                          in_code,
  input  logic [7:0]                          in_color,
  input  logic [$clog2(COLUMNS)-1:0]          in_column,
  input  logic [$clog2(ROWS+1)-1:0]           in_row,
  output logic                                cmd_valid,
  output tcs_pkg::cmd_t                       cmd,
  output logic [$clog2(COLUMNS*ROWS)-1:0]     cmd_addr,
  input  logic                                cmd_pop
);

  import tcs_pkg::*;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS + 1);
  localparam int ADDR_W = $clog2(COLUMNS * ROWS);

  cmd_t              cls_cmd;
  logic [ADDR_W-1:0] cls_addr;
  logic              in_range;

  cmd_t              q_cmd  [2];
  logic [ADDR_W-1:0] q_addr [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              push;

  assign in_range = ({1'b0, in_column} < (COL_W + 1)'(COLUMNS)) &&
                    ({1'b0, in_row} < (ROW_W + 1)'(ROWS));
  assign cls_addr = ADDR_W'(32'(in_row) * COLUMNS + 32'(in_column));

  always_comb begin
    cls_cmd.code  = in_code;
    cls_cmd.color = in_color;
    unique case (in_kind)
      KIND_PUT:   cls_cmd.op = (in_code == NEWLINE_CODE) ? OP_NEWLINE : OP_PUT;
      KIND_WRITE: cls_cmd.op = in_range ? OP_WRITE : OP_NOP;
      KIND_READ:  cls_cmd.op = in_range ? OP_READ : OP_NOP;
      default:    cls_cmd.op = OP_NOP;
    endcase
  end

  assign in_ready  = (count != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q_cmd[rd_ptr];
  assign cmd_addr  = q_addr[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_cmd[wr_ptr]  <= cls_cmd;
      q_addr[wr_ptr] <= cls_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule

// ===== hw/rtl/tcs_back.sv =====
module tcs_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [7:0]                      text_color,
  input  logic                            cmd_valid,
  input  tcs_pkg::cmd_t                   cmd,
  input  logic [$clog2(COLUMNS*ROWS)-1:0] cmd_addr,
  output logic                            cmd_pop,
  output logic                            clearing,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [15:0]                     out_value,
  output logic [$clog2(COLUMNS)-1:0]      out_column,
  output logic [$clog2(ROWS+1)-1:0]       out_row
);

  import tcs_pkg::*;

  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS + 1);
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] LAST_COPY  = ADDR_W'(CELL_COUNT - COLUMNS - 1);
  localparam logic [ADDR_W-1:0] LAST_ROW0  = ADDR_W'(CELL_COUNT - COLUMNS);
  localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);
  localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  ROW_PEND   = ROW_W'(ROWS);
  localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);

  state_t            state;
  state_t            state_next;
  logic [ADDR_W-1:0] cnt;
  logic              cp_valid;
  logic [ADDR_W-1:0] cp_addr;
  logic [COL_W-1:0]  cur_col;
  logic [COL_W-1:0]  cur_col_next;
  logic [ROW_W-1:0]  cur_line;
  logic [ROW_W-1:0]  cur_line_next;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [15:0]       ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [15:0]       ram_rdata;

  logic              slot_free;
  logic              res_load;
  logic [15:0]       res_value;
  logic              scroll_pending;
  logic [ADDR_W-1:0] put_addr;

  assign slot_free      = !out_valid || out_ready;
  assign scroll_pending = (cur_line == ROW_PEND);
  assign put_addr       = ADDR_W'(32'(cur_line) * COLUMNS + 32'(cur_col));
  assign clearing       = (state == ST_INIT);

  tcs_ram #(
    .WIDTH (16),
    .DEPTH (CELL_COUNT)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: begin
        if (cnt == LAST_CELL) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.op == OP_PUT && scroll_pending) begin
            state_next = ST_SCROLL;
          end else if (cmd.op == OP_READ) begin
            state_next = ST_READ;
          end
        end
      end
      ST_SCROLL: begin
        if (cnt == LAST_COPY) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_CLEAR;
      ST_CLEAR: begin
        if (cnt == LAST_CELL) begin
          state_next = ST_IDLE;
        end
      end
      ST_READ: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_INIT;
    endcase
  end

  always_comb begin
    ram_we        = 1'b0;
    ram_waddr     = cnt;
    ram_wdata     = {text_color, SPACE_CODE};
    ram_re        = 1'b0;
    ram_raddr     = cmd_addr;
    cmd_pop       = 1'b0;
    res_load      = 1'b0;
    res_value     = 16'd0;
    cur_col_next  = cur_col;
    cur_line_next = cur_line;
    unique case (state)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = {COLOR_RESET, SPACE_CODE};
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.op == OP_READ) begin
            ram_re  = 1'b1;
            cmd_pop = 1'b1;
          end else if (!(cmd.op == OP_PUT && scroll_pending) && slot_free) begin
            cmd_pop  = 1'b1;
            res_load = 1'b1;
            case (cmd.op)
              OP_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = put_addr;
                ram_wdata = {text_color, cmd.code};
                if (cur_col == LAST_COL) begin
                  cur_col_next  = '0;
                  cur_line_next = cur_line + ROW_W'(1);
                end else begin
                  cur_col_next = cur_col + COL_W'(1);
                end
              end
              OP_NEWLINE: begin
                cur_col_next = '0;
                if (!scroll_pending) begin
                  cur_line_next = cur_line + ROW_W'(1);
                end
              end
              OP_WRITE: begin
                ram_we    = 1'b1;
                ram_waddr = cmd_addr;
                ram_wdata = {cmd.color, cmd.code};
              end
              default: ;
            endcase
          end
        end
      end
      ST_SCROLL: begin
        // Read one row ahead; the copy lands in the following cycle.
        ram_re    = 1'b1;
        ram_raddr = cnt + ROW_STRIDE;
        ram_we    = cp_valid;
        ram_waddr = cp_addr;
        ram_wdata = ram_rdata;
      end
      ST_DRAIN: begin
        ram_we    = 1'b1;
        ram_waddr = cp_addr;
        ram_wdata = ram_rdata;
      end
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (cnt == LAST_CELL) begin
          cur_line_next = ROW_LAST;
        end
      end
      ST_READ: begin
        if (slot_free) begin
          res_load  = 1'b1;
          res_value = ram_rdata;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      cnt       <= '0;
      cp_valid  <= 1'b0;
      cur_col   <= '0;
      cur_line  <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      cp_valid <= (state == ST_SCROLL);
      cur_col  <= cur_col_next;
      cur_line <= cur_line_next;
      unique case (state)
        ST_INIT:   cnt <= cnt + ADDR_W'(1);
        ST_IDLE:   cnt <= '0;
        ST_SCROLL: cnt <= (cnt == LAST_COPY) ? LAST_ROW0 : cnt + ADDR_W'(1);
        ST_CLEAR:  cnt <= cnt + ADDR_W'(1);
        default:   cnt <= cnt;
      endcase
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cp_addr <= cnt;
    if (res_load) begin
      out_value  <= res_value;
      out_column <= cur_col_next;
      out_row    <= cur_line_next;
    end
  end

endmodule

// ===== hw/rtl/text_terminal_cursor_scroll.sv =====
// Text-mode screen store with a cursor, line wrap and scrolling.
// Input beats arrive on the s_ stream: tuser carries the kind (put at cursor,
// direct cell write, cell read), tdata the character, color and cell address.
// Every accepted beat yields exactly one result beat on the m_ stream with the
// read cell (zero for other kinds) and the cursor position after the beat.
// The cfg channel writes the text color used for put characters and for the
// line cleared by a scroll; write it only while the block is idle.
// A front end classifies beats into a two-entry queue; the back end executes
// them against a single-port-write, registered-read cell memory.
// The back end takes one beat per cycle while the receiver keeps up and no
// scroll runs; after a read it takes no new beat until the result is loaded.
// A put while a scroll is pending first runs the copy loop, which moves one
// cell per cycle through the memory port, then the last row clears.
// After reset the block sweeps the memory to spaces in color 245, one cell per
// cycle; s_tready stays low until the sweep ends.
// When the receiver stalls, the result waits in the output register while the
// queue takes beats until full; the back end stops once the register is occupied.
module text_terminal_cursor_scroll #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // char_code, cell_color, column, row; zero padded
  input  logic [((16 + $clog2(COLUMNS) + $clog2(ROWS+1) + 7) / 8) * 8 - 1:0] s_tdata,
  // kind
  input  logic [1:0]           s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // cell_value, cursor_column, cursor_row; zero padded
  output logic [((16 + $clog2(COLUMNS) + $clog2(ROWS+1) + 7) / 8) * 8 - 1:0] m_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_data
);

  import tcs_pkg::*;

  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ROW_W   = $clog2(ROWS + 1);
  localparam int ADDR_W  = $clog2(COLUMNS * ROWS);
  localparam int FIELD_W = 16 + COL_W + ROW_W;
  localparam int DATA_W  = ((FIELD_W + 7) / 8) * 8;

  logic [7:0]        text_color;
  logic              front_ready;
  logic              clearing;
  logic              cmd_valid;
  cmd_t              cmd;
  logic [ADDR_W-1:0] cmd_addr;
  logic              cmd_pop;
  logic [15:0]       out_value;
  logic [COL_W-1:0]  out_column;
  logic [ROW_W-1:0]  out_row;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= COLOR_RESET;
    end else if (cfg_valid) begin
      text_color <= cfg_data;
    end
  end

  assign s_tready = front_ready && !clearing;

  tcs_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid && !clearing),
    .in_ready  (front_ready),
    .in_kind   (s_tuser),
    .in_code   (s_tdata[7:0]),
    .in_color  (s_tdata[15:8]),
    .in_column (s_tdata[16 +: COL_W]),
    .in_row    (s_tdata[16 + COL_W +: ROW_W]),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_addr  (cmd_addr),
    .cmd_pop   (cmd_pop)
  );

  tcs_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .text_color (text_color),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_addr   (cmd_addr),
    .cmd_pop    (cmd_pop),
    .clearing   (clearing),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_value  (out_value),
    .out_column (out_column),
    .out_row    (out_row)
  );

  assign m_tdata = DATA_W'({out_row, out_column, out_value});

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
  import tcs_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ROW_W   = $clog2(ROWS + 1);
  localparam int DATA_W  = ((16 + COL_W + ROW_W + 7) / 8) * 8;
  localparam int COL_LO  = 16;
  localparam int ROW_LO  = 16 + COL_W;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int SETTLE_CYCLES = 8;

  // The package names only the three kinds in use; the fourth does nothing.
  localparam logic [1:0] KIND_NONE = 2'd3;

  typedef struct {
    logic [15:0]      cell_value;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } cursor_report_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;
  logic [1:0]        s_tuser = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [7:0]        cfg_data = '0;

  // Mirror of the screen, the cursor and the text color register.
  logic [15:0]    screen_mirror [0:CELLS-1];
  int             cur_col;
  int             cur_line;
  logic [7:0]     text_color_mirror;
  int             scroll_count;
  cursor_report_t expected_reports [$];

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int error_count = 0;
  int cycle_count = 0;

  text_terminal_cursor_scroll #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR cycle %0d: %s got 0x%0h expected 0x%0h", cycle_count, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    cursor_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_reports.size() == 0) begin
        report_mismatch("beat with nothing expected", m_tdata, 0);
      end else begin
        want = expected_reports.pop_front();
        if (m_tdata[15:0] !== want.cell_value)
          report_mismatch("cell_value", int'(m_tdata[15:0]), int'(want.cell_value));
        if (m_tdata[COL_LO +: COL_W] !== want.col)
          report_mismatch("cursor_column", int'(m_tdata[COL_LO +: COL_W]), int'(want.col));
        if (m_tdata[ROW_LO +: ROW_W] !== want.row)
          report_mismatch("cursor_row", int'(m_tdata[ROW_LO +: ROW_W]), int'(want.row));
      end
    end
  end

  task automatic reset_mirror();
    for (int i = 0; i < CELLS; i++) screen_mirror[i] = {COLOR_RESET, SPACE_CODE};
    cur_col = 0;
    cur_line = 0;
    text_color_mirror = COLOR_RESET;
    scroll_count = 0;
  endtask

  task automatic next_line();
    cur_col = 0;
    if (cur_line < ROWS) cur_line++;
  endtask

  // Works out the effect of one accepted beat and queues the expected report.
  task automatic apply_terminal_item(input logic [1:0] kind, input logic [7:0] code,
                                     input logic [7:0] color, input logic [COL_W-1:0] col,
                                     input logic [ROW_W-1:0] row);
    cursor_report_t rep;
    logic in_range;
    in_range = (col < COLUMNS) && (row < ROWS);
    rep.cell_value = '0;
    case (kind)
      KIND_PUT: begin
        if (code == NEWLINE_CODE) begin
          next_line();
        end else begin
          if (cur_line >= ROWS) begin
            for (int i = 0; i < CELLS - COLUMNS; i++) screen_mirror[i] = screen_mirror[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++)
              screen_mirror[i] = {text_color_mirror, SPACE_CODE};
            cur_line = ROWS - 1;
            scroll_count++;
          end
          if (cur_col >= COLUMNS) cur_col = 0;
          screen_mirror[cur_line * COLUMNS + cur_col] = {text_color_mirror, code};
          cur_col++;
          if (cur_col >= COLUMNS) next_line();
        end
      end
      KIND_WRITE: begin
        if (in_range) screen_mirror[row * COLUMNS + col] = {color, code};
      end
      KIND_READ: begin
        if (in_range) rep.cell_value = screen_mirror[row * COLUMNS + col];
      end
      default: ;
    endcase
    rep.col = cur_col[COL_W-1:0];
    rep.row = cur_line[ROW_W-1:0];
    expected_reports.push_back(rep);
  endtask

  task automatic send_item(input logic [1:0] kind, input logic [7:0] code,
                           input logic [7:0] color, input int col, input int row);
    logic [DATA_W-1:0] packed_item;
    packed_item = '0;
    packed_item[7:0] = code;
    packed_item[15:8] = color;
    packed_item[COL_LO +: COL_W] = col[COL_W-1:0];
    packed_item[ROW_LO +: ROW_W] = row[ROW_W-1:0];
    if ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= packed_item;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    apply_terminal_item(kind, code, color, col[COL_W-1:0], row[ROW_W-1:0]);
  endtask

  task automatic put_char(input logic [7:0] code);
    send_item(KIND_PUT, code, 8'($urandom_range(255)), $urandom_range(127), $urandom_range(31));
  endtask

  task automatic read_cell(input int col, input int row);
    send_item(KIND_READ, 8'($urandom_range(255)), 8'($urandom_range(255)), col, row);
  endtask

  // Lowers valid and lets the block finish everything in flight.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_text_color(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    text_color_mirror = value;
  endtask

  task automatic test_directed_cases();
    read_cell(0, 0);
    read_cell(COLUMNS - 1, ROWS - 1);
    put_char(8'h41);
    put_char(8'h00);
    put_char(8'hFF);
    put_char(NEWLINE_CODE);
    read_cell(0, 0);
    read_cell(2, 0);
    send_item(KIND_WRITE, 8'hFF, 8'hFF, COLUMNS - 1, ROWS - 1);
    read_cell(COLUMNS - 1, ROWS - 1);
    send_item(KIND_WRITE, 8'h00, 8'h00, 0, 0);
    read_cell(0, 0);
    // Writes outside the screen must leave every cell alone.
    send_item(KIND_WRITE, 8'h55, 8'hAA, 127, 0);
    send_item(KIND_WRITE, 8'h55, 8'hAA, 0, 31);
    send_item(KIND_WRITE, 8'h55, 8'hAA, COLUMNS, ROWS);
    read_cell(127, 31);
    read_cell(COLUMNS, 0);
    read_cell(0, ROWS);
    read_cell(COLUMNS - 1, 0);
    send_item(KIND_NONE, 8'hFF, 8'hFF, 127, 31);
    send_item(KIND_NONE, 8'h00, 8'h00, 0, 0);
    read_cell(0, 0);
  endtask

  // Fills one whole line so the cursor wraps, then reads cells of that line back.
  task automatic test_line_wrap();
    int line;
    line = cur_line;
    while (cur_col != 0) put_char(8'($urandom_range(11, 255)));
    line = cur_line;
    for (int i = 0; i < COLUMNS; i++) put_char(8'($urandom_range(11, 255)));
    for (int i = 0; i < 12; i++) read_cell($urandom_range(COLUMNS - 1), line);
    read_cell(0, line);
    read_cell(COLUMNS - 1, line);
  endtask

  // Short lines until the screen has scrolled several times.
  task automatic test_scroll();
    int target;
    target = scroll_count + 4;
    while (scroll_count < target) begin
      repeat ($urandom_range(0, 6)) put_char(8'($urandom_range(11, 255)));
      put_char(NEWLINE_CODE);
    end
    for (int i = 0; i < 16; i++)
      read_cell($urandom_range(COLUMNS - 1), $urandom_range(ROWS - 3, ROWS - 1));
    // A newline while a scroll is pending stays at the pending row.
    while (cur_line < ROWS) put_char(NEWLINE_CODE);
    put_char(NEWLINE_CODE);
    put_char(8'($urandom_range(11, 255)));
    read_cell(0, ROWS - 1);
    read_cell(COLUMNS - 1, ROWS - 1);
    read_cell(COLUMNS - 1, ROWS - 2);
  endtask

  task automatic test_random_traffic(input int item_count);
    int sent;
    int pick;
    int run;
    int row;
    sent = 0;
    while (sent < item_count) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        // A run of text, now and then long enough to wrap the line.
        run = ($urandom_range(3) == 0) ? $urandom_range(60, 85) : $urandom_range(1, 12);
        repeat (run) put_char(8'($urandom_range(255)));
        sent += run;
      end else if (pick < 37) begin
        put_char(NEWLINE_CODE);
        sent++;
      end else if (pick < 55) begin
        if ($urandom_range(19) == 0)
          send_item(KIND_WRITE, 8'($urandom_range(255)), 8'($urandom_range(255)),
                    $urandom_range(COLUMNS, 127), $urandom_range(31));
        else
          send_item(KIND_WRITE, 8'($urandom_range(255)), 8'($urandom_range(255)),
                    $urandom_range(COLUMNS - 1), $urandom_range(ROWS - 1));
        sent++;
      end else if (pick < 92) begin
        if ($urandom_range(19) == 0) begin
          read_cell($urandom_range(127), $urandom_range(ROWS, 31));
        end else if ($urandom_range(1) == 0) begin
          row = (cur_line >= ROWS) ? ROWS - 1 : cur_line;
          row = row - $urandom_range(0, 2);
          read_cell($urandom_range(COLUMNS - 1), (row < 0) ? 0 : row);
        end else begin
          read_cell($urandom_range(COLUMNS - 1), $urandom_range(ROWS - 1));
        end
        sent++;
      end else begin
        send_item(2'($urandom_range(3)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                  $urandom_range(127), $urandom_range(31));
        sent++;
      end
    end
  endtask

  task automatic run_idle_phase(input int idle_pct, input int stall_pct,
                                input logic [7:0] color, input int item_count);
    wait_drained();
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    write_text_color(color);
    test_random_traffic(item_count);
  endtask

  initial begin
    reset_mirror();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    wait_drained();
    write_text_color(8'h00);
    test_line_wrap();
    wait_drained();
    write_text_color(8'hFF);
    test_scroll();

    run_idle_phase(0, 0, 8'($urandom_range(255)), 330);
    run_idle_phase(67, 0, 8'h00, 330);
    run_idle_phase(0, 67, 8'hFF, 330);
    run_idle_phase(37, 37, 8'($urandom_range(255)), 330);

    wait_drained();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/tcs_pkg.sv
hw/rtl/tcs_ram.sv
hw/rtl/tcs_front.sv
hw/rtl/tcs_back.sv
hw/rtl/text_terminal_cursor_scroll.sv
sim/tb_top.sv
